### rtl/udiv_pkg.sv
package udiv_pkg;

    // Width of the payload ports; the datapath width is a parameter up to this.
    localparam int PORT_WIDTH = 64;

    // Default datapath width handed to the top level.
    localparam int DATA_WIDTH_DEF = 64;

    // Result selection codes carried by the mode field.
    localparam logic MODE_QUOTIENT  = 1'b0;
    localparam logic MODE_REMAINDER = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } udiv_state_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } udiv_ctl_t;

endpackage

### rtl/unsigned_divider_64.sv
// Channel   Handshake             Fields
// input     in_valid / in_stall   mode, dividend, divisor
// output    out_valid / out_stall result
//
// From acceptance to the next possible acceptance an item is loaded, takes
// DATA_WIDTH steps of the shared subtractor (one quotient bit each), and
// is delivered once its result is taken.
// The block holds one item at a time; in_stall stays high from acceptance
// until the result has been taken, and a stalled result holds its value.
// Reset returns the sequencer to idle; the datapath registers need none.
module unsigned_divider_64
    import udiv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [PORT_WIDTH-1:0] dividend,
    input  logic [PORT_WIDTH-1:0] divisor,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PORT_WIDTH-1:0] result
);

    udiv_ctl_t             ctl;
    logic [DATA_WIDTH-1:0] dp_result;

    // The sequencer loads an accepted item, then steps the datapath once
    // per quotient bit, then presents the result until it is taken.
    udiv_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    // Operand bits above the datapath width are ignored.
    udiv_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .ctl      (ctl),
        .mode     (mode),
        .dividend (dividend[DATA_WIDTH-1:0]),
        .divisor  (divisor[DATA_WIDTH-1:0]),
        .result   (dp_result)
    );

    // Upper result bits read as zero for a narrow datapath.
    assign result = PORT_WIDTH'(dp_result);

endmodule

### rtl/udiv_ctrl.sv
module udiv_ctrl
    import udiv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output udiv_ctl_t ctl
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    udiv_state_t      state_reg;
    udiv_state_t      state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ctl        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    count_next = CNT_W'(DATA_WIDTH - 1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                ctl.step   = 1'b1;
                count_next = count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/udiv_datapath.sv
module udiv_datapath
    import udiv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  udiv_ctl_t             ctl,
    input  logic                  mode,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic [DATA_WIDTH-1:0] result
);

    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] div_reg;
    logic                  mode_reg;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH+1:0] diff;
    logic                  fits;

    // The shared subtractor: partial remainder with the next dividend bit
    // brought in, less the divisor. No borrow means the divisor fits.
    assign shifted = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {2'b00, div_reg};
    assign fits    = ~diff[DATA_WIDTH+1];

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            div_reg  <= divisor;
            mode_reg <= mode;
        end
        else if (ctl.step)
        begin
            if (fits)
            begin
                rem_reg <= diff[DATA_WIDTH-1:0];
            end
            else
            begin
                rem_reg <= shifted[DATA_WIDTH-1:0];
            end
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], fits};
        end
    end

    // With a zero divisor every step fits, so the remainder ends as the
    // dividend and only the quotient needs forcing to zero.
    always_comb
    begin
        if (mode_reg == MODE_REMAINDER)
        begin
            result = rem_reg;
        end
        else if (div_reg == '0)
        begin
            result = '0;
        end
        else
        begin
            result = quo_reg;
        end
    end

endmodule

### rtl/udiv_checker.sv
module udiv_checker
    import udiv_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [PORT_WIDTH-1:0] result
);

    // Once an item is taken, no other is taken until its result is out.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while an item is in progress");

    // A waiting result keeps the input side closed.
    a_stall_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result is pending");

    // Exactly one result per item: valid drops after the result is taken.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result repeated after delivery");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result)))
        else $error("stalled result changed");

endmodule

bind unsigned_divider_64 udiv_checker u_udiv_checker (.*);

### dv/unsigned_divider_64_tb.sv
`timescale 1ns / 1ps

module unsigned_divider_64_tb;

    import udiv_pkg::*;

    // Datapath width of the instance under test; the predictor masks with it.
    localparam int DIV_WIDTH = DATA_WIDTH_DEF;

    // Length of the long output hold-off, in clock cycles. It is several times
    // the time of one division, so the block is certain to fill and stall.
    localparam int HOLD_OFF_CYCLES = 500;

    // Cycles allowed after the last result, to catch a stray extra result.
    localparam int SETTLE_CYCLES = DIV_WIDTH + 16;

    // One accepted division together with the answer that it must give.
    typedef struct {
        logic                  mode;
        logic [PORT_WIDTH-1:0] dividend;
        logic [PORT_WIDTH-1:0] divisor;
        logic [PORT_WIDTH-1:0] result;
    } division_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  mode;
    logic [PORT_WIDTH-1:0] dividend;
    logic [PORT_WIDTH-1:0] divisor;
    logic                  out_valid;
    logic                  out_stall;
    logic [PORT_WIDTH-1:0] result;

    // Divisions accepted by the block whose results have not come back yet,
    // oldest first.
    division_t pending_divisions[$];

    int error_count = 0;

    // When set, neither the sender nor the receiver inserts random gaps.
    bit quiet = 1'b0;

    // Set by a test to ask the receiver for one long hold-off.
    bit hold_off_req = 1'b0;

    unsigned_divider_64 #(
        .DATA_WIDTH(DIV_WIDTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .dividend (dividend),
        .divisor  (divisor),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result   (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // The run must never take this long; if it does, the block has hung.
    initial
    begin
        #3_000_000;
        $display("unsigned_divider_64_tb NOT OK");
        $finish;
    end

    // Restoring division, one quotient bit per position: normalize the
    // divisor so its top bit is set, then walk back down trying a
    // subtraction at each position. A zero divisor gives quotient 0 and
    // leaves the dividend as the remainder.
    function automatic logic [PORT_WIDTH-1:0] udiv_answer(
        input logic                  sel,
        input logic [PORT_WIDTH-1:0] num_in,
        input logic [PORT_WIDTH-1:0] den_in
    );
        logic [PORT_WIDTH-1:0] width_mask;
        logic [PORT_WIDTH-1:0] top_bit;
        logic [PORT_WIDTH-1:0] num;
        logic [PORT_WIDTH-1:0] den;
        logic [PORT_WIDTH-1:0] qbit;
        logic [PORT_WIDTH-1:0] quot;
        int                    steps;
        width_mask = {PORT_WIDTH{1'b1}} >> (PORT_WIDTH - DIV_WIDTH);
        top_bit    = {{(PORT_WIDTH-1){1'b0}}, 1'b1} << (DIV_WIDTH - 1);
        num        = num_in & width_mask;
        den        = den_in & width_mask;
        qbit       = 1;
        quot       = '0;
        if (den == '0)
        begin
            return (sel == MODE_REMAINDER) ? num : '0;
        end
        for (steps = 0; steps < DIV_WIDTH && (den & top_bit) == '0; steps++)
        begin
            den  = (den << 1) & width_mask;
            qbit = qbit << 1;
        end
        for (steps = 0; steps < DIV_WIDTH && qbit != '0; steps++)
        begin
            if (den <= num)
            begin
                num  = num - den;
                quot = quot | qbit;
            end
            den  = den >> 1;
            qbit = qbit >> 1;
        end
        return (sel == MODE_REMAINDER) ? (num & width_mask) : (quot & width_mask);
    endfunction

    function automatic logic [PORT_WIDTH-1:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    // A value whose highest set bit lies at a random position, so that the
    // normalization shift and the number of quotient bits vary widely.
    function automatic logic [PORT_WIDTH-1:0] random_sized_word();
        int span;
        span = $urandom_range(1, PORT_WIDTH);
        return random_word() >> (PORT_WIDTH - span);
    endfunction

    // Offers one division and returns once the block has accepted it. Inputs
    // change only at the falling edge. The valid stays high on return, so a
    // following call can present the next item back to back; it is lowered
    // only when a gap is inserted or the sender pauses.
    task automatic send_division(
        input logic                  sel,
        input logic [PORT_WIDTH-1:0] num,
        input logic [PORT_WIDTH-1:0] den
    );
        division_t entry;
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= sel;
        dividend <= num;
        divisor  <= den;
        do
        begin
            @(posedge clk);
        end
        while (!(in_valid && !in_stall));
        entry.mode     = sel;
        entry.dividend = num;
        entry.divisor  = den;
        entry.result   = udiv_answer(sel, num, den);
        pending_divisions.push_back(entry);
    endtask

    // Drops the valid and waits until every accepted division has answered.
    task automatic wait_for_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_divisions.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Zero divisor, divisor above dividend, extremes of both operands and a
    // divisor that needs no normalization shift, most of them in both modes.
    task automatic test_corner_cases();
        logic [PORT_WIDTH-1:0] all_ones;
        logic [PORT_WIDTH-1:0] msb_only;
        all_ones = '1;
        msb_only = {1'b1, {(PORT_WIDTH-1){1'b0}}};
        send_division(MODE_QUOTIENT,  all_ones, '0);
        send_division(MODE_REMAINDER, all_ones, '0);
        send_division(MODE_QUOTIENT,  '0, '0);
        send_division(MODE_REMAINDER, '0, '0);
        send_division(MODE_REMAINDER, random_word(), '0);
        send_division(MODE_QUOTIENT,  64'd5, 64'd7);
        send_division(MODE_REMAINDER, 64'd5, 64'd7);
        send_division(MODE_QUOTIENT,  all_ones - 1, all_ones);
        send_division(MODE_REMAINDER, all_ones - 1, all_ones);
        send_division(MODE_QUOTIENT,  all_ones, all_ones);
        send_division(MODE_REMAINDER, all_ones, all_ones);
        send_division(MODE_QUOTIENT,  all_ones, 64'd1);
        send_division(MODE_REMAINDER, all_ones, 64'd1);
        send_division(MODE_QUOTIENT,  '0, 64'd1);
        send_division(MODE_QUOTIENT,  all_ones, msb_only);
        send_division(MODE_REMAINDER, all_ones, msb_only);
        send_division(MODE_QUOTIENT,  msb_only, 64'd3);
        send_division(MODE_REMAINDER, msb_only, 64'd3);
        send_division(MODE_QUOTIENT,  random_word(), random_sized_word());
        send_division(MODE_REMAINDER, random_word(), random_sized_word());
    endtask

    // Random divisions. Most pair a full dividend with a divisor of random
    // size; some draw both at random size, so the divisor often exceeds the
    // dividend; a few use a zero divisor. The middle third runs with no
    // gaps on either side.
    task automatic test_random_divisions(input int count);
        logic [PORT_WIDTH-1:0] num;
        logic [PORT_WIDTH-1:0] den;
        int                    pick;
        for (int n = 0; n < count; n++)
        begin
            quiet = (n >= count / 3) && (n < 2 * count / 3);
            pick  = $urandom_range(0, 99);
            if (pick < 60)
            begin
                num = random_word();
                den = random_sized_word();
            end
            else if (pick < 95)
            begin
                num = random_sized_word();
                den = random_sized_word();
            end
            else
            begin
                num = random_word();
                den = '0;
            end
            send_division($urandom_range(0, 1) ? MODE_REMAINDER : MODE_QUOTIENT, num, den);
        end
        quiet = 1'b0;
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering items, so the block fills and must stall its input.
    task automatic test_output_hold_off();
        hold_off_req = 1'b1;
        for (int n = 0; n < 4; n++)
        begin
            send_division($urandom_range(0, 1) ? MODE_REMAINDER : MODE_QUOTIENT,
                          random_word(), random_sized_word());
        end
    endtask

    // The sender pauses until every result is back, then starts again from
    // an empty block.
    task automatic test_sender_pause();
        wait_for_all_results();
        for (int n = 0; n < 4; n++)
        begin
            send_division($urandom_range(0, 1) ? MODE_REMAINDER : MODE_QUOTIENT,
                          random_word(), random_sized_word());
        end
    endtask

    // Receiver: stalls at random about 7 percent of the time, except during
    // quiet stretches, and serves one long hold-off when a test asks for it.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++)
                begin
                    @(negedge clk);
                end
            end
            else
            begin
                out_stall <= !quiet && ($urandom_range(0, 99) < 7);
            end
        end
    end

    // Every result taken from the block is compared with the oldest pending
    // division. Sampling happens at the rising edge, before the block updates.
    always @(posedge clk)
    begin
        division_t head;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_divisions.size() == 0)
            begin
                $display("%0t: result %0h with no division pending", $time, result);
                error_count++;
            end
            else
            begin
                head = pending_divisions.pop_front();
                if (result !== head.result)
                begin
                    $display("%0t: mode %0d, %0h / %0h: expected %0h, actual %0h",
                             $time, head.mode, head.dividend, head.divisor,
                             head.result, result);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        mode     = MODE_QUOTIENT;
        dividend = '0;
        divisor  = '0;
        repeat (10)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_cases();
        test_random_divisions(200);
        test_output_hold_off();
        test_sender_pause();
        test_random_divisions(200);

        // Wait for the last results, then a little longer so that any extra
        // result from the block would still be seen by the checker.
        wait_for_all_results();
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
        if (error_count == 0)
        begin
            $display("unsigned_divider_64_tb OK");
        end
        else
        begin
            $display("unsigned_divider_64_tb NOT OK");
        end
        $finish;
    end

endmodule
